// ===== sv/rmt_pkg.sv =====
package rmt_pkg;

  localparam int TYPE_W = 2;
  localparam int POS_W  = 10;
  localparam int VAL_W  = 30;
  localparam int ACT_W  = 11;

  localparam logic [VAL_W-1:0] EMPTY_VALUE = VAL_W'(1000000010);
  localparam logic [VAL_W-1:0] MAX_VALUE   = VAL_W'(1000000009);

  localparam logic [TYPE_W-1:0] REQ_ASSIGN = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_QUERY  = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_POINT  = 2'd2;

  localparam logic [1:0] PH_ENTER = 2'd0;
  localparam logic [1:0] PH_LEFT  = 2'd1;
  localparam logic [1:0] PH_RIGHT = 2'd2;

  typedef logic [3:0] cmd_t;

  localparam cmd_t CMD_NOP      = 4'd0;
  localparam cmd_t CMD_CLEAR    = 4'd1;
  localparam cmd_t CMD_LOAD     = 4'd2;
  localparam cmd_t CMD_COVER_WR = 4'd3;
  localparam cmd_t CMD_RD_NODE  = 4'd4;
  localparam cmd_t CMD_ACC      = 4'd5;
  localparam cmd_t CMD_POP      = 4'd6;
  localparam cmd_t CMD_PD_L     = 4'd7;
  localparam cmd_t CMD_PD_R     = 4'd8;
  localparam cmd_t CMD_PD_SELF  = 4'd9;
  localparam cmd_t CMD_PUSH_L   = 4'd10;
  localparam cmd_t CMD_PUSH_R   = 4'd11;
  localparam cmd_t CMD_RD_LEFT  = 4'd12;
  localparam cmd_t CMD_RD_RIGHT = 4'd13;
  localparam cmd_t CMD_WR_MIN   = 4'd14;
  localparam cmd_t CMD_EMIT     = 4'd15;

  typedef struct packed {
    cmd_t cmd;
  } ctl_t;

  typedef struct packed {
    logic       clear_last;
    logic       no_work;
    logic       is_query;
    logic       is_assign;
    logic [1:0] ph;
    logic       disjoint;
    logic       covered;
    logic       at_root;
    logic       rd_pend;
    logic       out_free;
  } stat_t;

  function automatic logic [VAL_W-1:0] umin(input logic [VAL_W-1:0] a,
                                            input logic [VAL_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

// ===== sv/range_assign_range_min_tree.sv =====
// After reset a clearing pass writes every tree node, with no input request accepted.
// One request is in flight at a time; the walk uses an explicit frame stack in the datapath.
// An empty assign or an unused type returns to idle from the start state; an empty query still emits a result.
// Otherwise the walk visits nodes one at a time over the one node memory port; a query result
// is registered from the done state once the output register is free.
// Configuration beats are always taken; the position count resets to LEAVES.
module range_assign_range_min_tree #(
  parameter int LEAVES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // range_lo[9:0], range_hi[19:10], value[49:20]
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // result_value[29:0]
  output logic [0:0]  out_tuser,  // range_empty[0]
  input  logic        cfg_tvalid,
  output logic        cfg_tready,
  input  logic [15:0] cfg_tdata   // active_size[10:0]
);
  import rmt_pkg::*;

  ctl_t  ctl;
  stat_t st;

  assign cfg_tready = 1'b1;

  rmt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .ctl       (ctl)
  );

  rmt_dp #(
    .LEAVES (LEAVES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .st         (st),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_tvalid (cfg_tvalid),
    .cfg_tdata  (cfg_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== sv/rmt_ram.sv =====
module rmt_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [W-1:0]             wdata,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== sv/rmt_ctrl.sv =====
module rmt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  rmt_pkg::stat_t st,
  output rmt_pkg::ctl_t  ctl
);
  import rmt_pkg::*;

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_START = 4'd2;
  localparam logic [3:0] ST_VISIT = 4'd3;
  localparam logic [3:0] ST_QWAIT = 4'd4;
  localparam logic [3:0] ST_PDW   = 4'd5;
  localparam logic [3:0] ST_PDR   = 4'd6;
  localparam logic [3:0] ST_PDS   = 4'd7;
  localparam logic [3:0] ST_CMBL  = 4'd8;
  localparam logic [3:0] ST_CMBR  = 4'd9;
  localparam logic [3:0] ST_POP   = 4'd10;
  localparam logic [3:0] ST_DONE  = 4'd11;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    ctl.cmd   = CMD_NOP;
    unique case (state_r)
      ST_CLEAR: begin
        ctl.cmd = CMD_CLEAR;
        if (st.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          ctl.cmd   = CMD_LOAD;
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        if (st.no_work) state_nxt = st.is_query ? ST_DONE : ST_IDLE;
        else state_nxt = ST_VISIT;
      end
      ST_VISIT: begin
        case (st.ph)
          PH_ENTER: begin
            if (st.disjoint) begin
              state_nxt = ST_POP;
            end else if (st.covered) begin
              if (st.is_assign) begin
                ctl.cmd   = CMD_COVER_WR;
                state_nxt = ST_POP;
              end else begin
                ctl.cmd   = CMD_RD_NODE;
                state_nxt = ST_QWAIT;
              end
            end else begin
              ctl.cmd   = CMD_RD_NODE;
              state_nxt = ST_PDW;
            end
          end
          PH_LEFT: begin
            ctl.cmd   = CMD_PUSH_R;
            state_nxt = ST_VISIT;
          end
          default: begin
            if (st.is_assign) begin
              ctl.cmd   = CMD_RD_LEFT;
              state_nxt = ST_CMBL;
            end else begin
              state_nxt = ST_POP;
            end
          end
        endcase
      end
      ST_QWAIT: begin
        ctl.cmd   = CMD_ACC;
        state_nxt = ST_POP;
      end
      ST_PDW: begin
        if (st.rd_pend) begin
          ctl.cmd   = CMD_PD_L;
          state_nxt = ST_PDR;
        end else begin
          ctl.cmd   = CMD_PUSH_L;
          state_nxt = ST_VISIT;
        end
      end
      ST_PDR: begin
        ctl.cmd   = CMD_PD_R;
        state_nxt = ST_PDS;
      end
      ST_PDS: begin
        ctl.cmd   = CMD_PD_SELF;
        state_nxt = ST_VISIT;
      end
      ST_CMBL: begin
        ctl.cmd   = CMD_RD_RIGHT;
        state_nxt = ST_CMBR;
      end
      ST_CMBR: begin
        ctl.cmd   = CMD_WR_MIN;
        state_nxt = ST_POP;
      end
      ST_POP: begin
        if (st.at_root) begin
          state_nxt = st.is_query ? ST_DONE : ST_IDLE;
        end else begin
          ctl.cmd   = CMD_POP;
          state_nxt = ST_VISIT;
        end
      end
      ST_DONE: begin
        if (st.out_free) begin
          ctl.cmd   = CMD_EMIT;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_tready)
    else $error("input accepted during clearing pass");

  a_load_start: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.cmd == CMD_LOAD) |=> (state_r == ST_START))
    else $error("load not followed by start");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.cmd == CMD_EMIT) |-> st.out_free)
    else $error("result emitted over a waiting result");

endmodule

// ===== sv/rmt_dp.sv =====
module rmt_dp #(
  parameter int LEAVES = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rmt_pkg::ctl_t              ctl,
  output rmt_pkg::stat_t             st,
  input  logic [55:0]                in_tdata,
  input  logic [1:0]                 in_tuser,
  input  logic                       cfg_tvalid,
  input  logic [15:0]                cfg_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [31:0]                out_tdata,
  output logic [0:0]                 out_tuser
);
  import rmt_pkg::*;

  localparam int NODES = 2 * LEAVES;
  localparam int AW    = $clog2(NODES);
  localparam int NW    = $clog2(LEAVES + 1);
  localparam int XW    = (NW > ACT_W) ? NW : ACT_W;
  localparam int SD    = $clog2(LEAVES) + 1;
  localparam int SPW   = (SD > 1) ? $clog2(SD) : 1;
  localparam logic [XW-1:0] LEAVES_X = XW'(LEAVES);
  localparam logic [AW:0]   NODES_X  = (AW + 1)'(NODES);

  logic [XW-1:0]    n_r;
  logic             assign_r, query_r, nowork_r, empty_r;
  logic [XW-1:0]    lo_r, hi_r;
  logic [VAL_W-1:0] val_r, acc_r, m_r, left_r;
  logic [XW-1:0]    stk_l [SD];
  logic [XW-1:0]    stk_h [SD];
  logic [AW-1:0]    stk_i [SD];
  logic [1:0]       stk_ph [SD];
  logic [SPW-1:0]   sp_r, sp_inc;
  logic [AW-1:0]    clr_cnt_r;
  logic             rd_oor_r;
  logic             out_valid_r, out_empty_r;
  logic [VAL_W-1:0] out_val_r;

  logic [XW-1:0]    tl, th, mid;
  logic [XW:0]      lh_sum;
  logic [AW-1:0]    ti, ti_l, ti_r;
  logic [30:0]      rdata;
  logic [VAL_W-1:0] rd_val;
  logic [AW-1:0]    ram_addr;
  logic [30:0]      ram_wd;
  logic             ram_we_raw, ram_we, addr_ok;

  logic [TYPE_W-1:0] f_type;
  logic [XW-1:0]     f_lo, f_hi, f_hsrc, f_last, f_hic, cfg_x, cfg_clamp;
  logic [VAL_W-1:0]  f_val;
  logic              f_assign, f_query;

  assign sp_inc = sp_r + SPW'(1);
  assign tl     = stk_l[sp_r];
  assign th     = stk_h[sp_r];
  assign ti     = stk_i[sp_r];
  assign lh_sum = {1'b0, tl} + {1'b0, th};
  assign mid    = lh_sum[XW:1];
  assign ti_l   = {ti[AW-2:0], 1'b0};
  assign ti_r   = {ti[AW-2:0], 1'b1};
  assign rd_val = rd_oor_r ? '0 : rdata[VAL_W-1:0];

  assign f_type   = in_tuser;
  assign f_lo     = XW'(in_tdata[9:0]);
  assign f_hi     = XW'(in_tdata[19:10]);
  assign f_val    = (in_tdata[49:20] > MAX_VALUE) ? MAX_VALUE : in_tdata[49:20];
  assign f_assign = (f_type == REQ_ASSIGN);
  assign f_query  = (f_type == REQ_QUERY) || (f_type == REQ_POINT);
  assign f_last   = n_r - XW'(1);
  assign f_hsrc   = (f_type == REQ_POINT) ? f_lo : f_hi;
  assign f_hic    = (f_hsrc > f_last) ? f_last : f_hsrc;

  assign cfg_x     = XW'(cfg_tdata[ACT_W-1:0]);
  assign cfg_clamp = (cfg_x == '0) ? XW'(1) : ((cfg_x > LEAVES_X) ? LEAVES_X : cfg_x);

  always_comb begin
    ram_addr   = ti;
    ram_wd     = '0;
    ram_we_raw = 1'b0;
    case (ctl.cmd)
      CMD_CLEAR: begin
        ram_addr   = clr_cnt_r;
        ram_we_raw = 1'b1;
      end
      CMD_COVER_WR: begin
        ram_wd     = {1'b1, val_r};
        ram_we_raw = 1'b1;
      end
      CMD_PD_L: begin
        ram_addr   = ti_l;
        ram_wd     = {1'b1, rd_val};
        ram_we_raw = 1'b1;
      end
      CMD_PD_R: begin
        ram_addr   = ti_r;
        ram_wd     = {1'b1, m_r};
        ram_we_raw = 1'b1;
      end
      CMD_PD_SELF: begin
        ram_wd     = {1'b0, m_r};
        ram_we_raw = 1'b1;
      end
      CMD_RD_LEFT:  ram_addr = ti_l;
      CMD_RD_RIGHT: ram_addr = ti_r;
      CMD_WR_MIN: begin
        ram_wd     = {1'b0, umin(left_r, rd_val)};
        ram_we_raw = 1'b1;
      end
      default: ram_addr = ti;
    endcase
  end

  assign addr_ok = ({1'b0, ram_addr} < NODES_X);
  assign ram_we  = ram_we_raw && addr_ok;

  rmt_ram #(
    .W     (31),
    .DEPTH (NODES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wd),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r         <= LEAVES_X;
      sp_r        <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      nowork_r    <= 1'b1;
      assign_r    <= 1'b0;
      query_r     <= 1'b0;
    end else begin
      if (cfg_tvalid) begin
        n_r <= cfg_clamp;
      end
      if (ctl.cmd == CMD_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
      if (ctl.cmd == CMD_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (ctl.cmd)
        CMD_LOAD: begin
          assign_r <= f_assign;
          query_r  <= f_query;
          nowork_r <= !(f_assign || f_query) || (f_lo > f_hic);
          sp_r     <= '0;
        end
        CMD_POP:                          sp_r <= sp_r - SPW'(1);
        CMD_PUSH_L, CMD_PD_SELF, CMD_PUSH_R: sp_r <= sp_inc;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_oor_r <= !addr_ok;
    case (ctl.cmd)
      CMD_LOAD: begin
        lo_r      <= f_lo;
        hi_r      <= f_hic;
        val_r     <= f_val;
        acc_r     <= EMPTY_VALUE;
        empty_r   <= !(f_assign || f_query) || (f_lo > f_hic);
        stk_l[0]  <= '0;
        stk_h[0]  <= f_last;
        stk_i[0]  <= AW'(1);
        stk_ph[0] <= PH_ENTER;
      end
      CMD_ACC:      acc_r  <= umin(acc_r, rd_val);
      CMD_PD_L:     m_r    <= rd_val;
      CMD_RD_RIGHT: left_r <= rd_val;
      CMD_PUSH_L, CMD_PD_SELF: begin
        stk_ph[sp_r]   <= PH_LEFT;
        stk_l[sp_inc]  <= tl;
        stk_h[sp_inc]  <= mid;
        stk_i[sp_inc]  <= ti_l;
        stk_ph[sp_inc] <= PH_ENTER;
      end
      CMD_PUSH_R: begin
        stk_ph[sp_r]   <= PH_RIGHT;
        stk_l[sp_inc]  <= mid + XW'(1);
        stk_h[sp_inc]  <= th;
        stk_i[sp_inc]  <= ti_r;
        stk_ph[sp_inc] <= PH_ENTER;
      end
      CMD_EMIT: begin
        out_val_r   <= acc_r;
        out_empty_r <= empty_r;
      end
      default: ;
    endcase
  end

  assign st.clear_last = (clr_cnt_r == AW'(NODES - 1));
  assign st.no_work    = nowork_r;
  assign st.is_query   = query_r;
  assign st.is_assign  = assign_r;
  assign st.ph         = stk_ph[sp_r];
  assign st.disjoint   = (lo_r > th) || (hi_r < tl);
  assign st.covered    = (lo_r <= tl) && (th <= hi_r);
  assign st.at_root    = (sp_r == '0);
  assign st.rd_pend    = !rd_oor_r && rdata[VAL_W];
  assign st.out_free   = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_val_r};
  assign out_tuser  = out_empty_r;

  a_pd_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.cmd == CMD_PD_L) |-> ($past(ctl.cmd) == CMD_RD_NODE))
    else $error("push-down without node read");

  a_min_after_right: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.cmd == CMD_WR_MIN) |-> ($past(ctl.cmd) == CMD_RD_RIGHT))
    else $error("combine without right child read");

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.cmd == CMD_EMIT) |=> out_valid_r)
    else $error("emitted result not presented");

endmodule

// ===== sim/tb_range_assign_range_min_tree.sv =====
`timescale 1ns / 1ps

module tb_range_assign_range_min_tree;
  import rmt_pkg::*;

  localparam int LEAVES = 1024;
  localparam int NODES = 2 * LEAVES;
  localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 20000;

  typedef struct {
    logic [VAL_W-1:0] result_value;
    logic             range_empty;
  } result_t;

  class min_tree_scoreboard;
    logic [VAL_W-1:0] node_min [NODES];
    bit               node_pend [NODES];
    int unsigned      size_reg;
    result_t          pending_q[$];
    int               mismatches;

    function void clear_store();
      for (int i = 0; i < NODES; i++) begin
        node_min[i] = '0;
        node_pend[i] = 1'b0;
      end
      size_reg = LEAVES;
    endfunction

    function void set_size(logic [15:0] word);
      size_reg = word[10:0];
    endfunction

    function void push_mark(int unsigned i);
      if (node_pend[i]) begin
        node_min[2*i] = node_min[i];
        node_min[2*i+1] = node_min[i];
        node_pend[2*i] = 1'b1;
        node_pend[2*i+1] = 1'b1;
        node_pend[i] = 1'b0;
      end
    endfunction

    function void fill(int unsigned l, int unsigned r, int unsigned lo, int unsigned hi,
                       logic [VAL_W-1:0] v, int unsigned i);
      int unsigned mid;
      if (l > r || lo > r || hi < l) return;
      if (lo <= l && r <= hi) begin
        node_min[i] = v;
        node_pend[i] = 1'b1;
        return;
      end
      push_mark(i);
      mid = (l + r) >> 1;
      fill(l, mid, lo, hi, v, 2*i);
      fill(mid + 1, r, lo, hi, v, 2*i+1);
      node_min[i] = node_min[2*i] < node_min[2*i+1] ? node_min[2*i] : node_min[2*i+1];
    endfunction

    function logic [VAL_W-1:0] range_min(int unsigned l, int unsigned r, int unsigned lo,
                                         int unsigned hi, int unsigned i);
      int unsigned mid;
      logic [VAL_W-1:0] a, b;
      if (l > r || lo > r || hi < l) return EMPTY_VALUE;
      if (lo <= l && r <= hi) return node_min[i];
      push_mark(i);
      mid = (l + r) >> 1;
      a = range_min(l, mid, lo, hi, 2*i);
      b = range_min(mid + 1, r, lo, hi, 2*i+1);
      return a < b ? a : b;
    endfunction

    function logic [VAL_W-1:0] leaf_read(int unsigned l, int unsigned r, int unsigned pos,
                                         int unsigned i);
      int unsigned mid;
      if (l > r || r < pos || l > pos) return EMPTY_VALUE;
      if (l == r) return node_min[i];
      push_mark(i);
      mid = (l + r) >> 1;
      if (pos <= mid) return leaf_read(l, mid, pos, 2*i);
      return leaf_read(mid + 1, r, pos, 2*i+1);
    endfunction

    function void note_request(logic [1:0] kind, logic [55:0] data);
      int unsigned lo, hi, n;
      logic [VAL_W-1:0] v;
      result_t r;
      lo = data[9:0];
      hi = data[19:10];
      v = data[49:20];
      n = size_reg == 0 ? 1 : (size_reg > LEAVES ? LEAVES : size_reg);
      if (hi > n - 1) hi = n - 1;
      if (v > MAX_VALUE) v = MAX_VALUE;
      r.result_value = EMPTY_VALUE;
      r.range_empty = 1'b1;
      case (kind)
        REQ_ASSIGN: begin
          if (lo <= hi) fill(0, n - 1, lo, hi, v, 1);
        end
        REQ_QUERY: begin
          if (lo <= hi) begin
            r.result_value = range_min(0, n - 1, lo, hi, 1);
            r.range_empty = 1'b0;
          end
          pending_q.push_back(r);
        end
        REQ_POINT: begin
          if (lo < n) begin
            r.result_value = leaf_read(0, n - 1, lo, 1);
            r.range_empty = 1'b0;
          end
          pending_q.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [31:0] data, logic [0:0] flag);
      result_t e;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d empty %0d", data, flag);
        return;
      end
      e = pending_q.pop_front();
      if (data !== {2'b00, e.result_value} || flag[0] !== e.range_empty) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected %0d/%0d, got %0d/%0d",
                   e.result_value, e.range_empty, data, flag[0]);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        cfg_tvalid = 1'b0;
  logic        cfg_tready;
  logic [15:0] cfg_tdata = '0;

  min_tree_scoreboard board;
  int  idle_cycles;
  int  hold_cycles;
  bit  sink_wild;
  int unsigned span;

  range_assign_range_min_tree #(.LEAVES(LEAVES)) uut (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) board.note_request(in_tuser, in_tdata);
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata, out_tuser);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT + 2 * NODES) begin
      $display("tb_range_assign_range_min_tree: done, errors");
      $finish;
    end
  end

  initial begin
    int gap;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_tready <= 1'b0;
      end else if (out_tready && out_tvalid) begin
        gap = sink_wild ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
          out_tready <= 1'b0;
          hold_cycles = gap;
        end
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_request(logic [1:0] kind, logic [9:0] lo, logic [9:0] hi,
                              logic [29:0] v, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 16) : 0;
    repeat (gap + 1) @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {6'b0, v, hi, lo};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic drain();
    while (board.pending_q.size() != 0 || !in_tready) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_size(logic [15:0] word);
    drain();
    cfg_tvalid <= 1'b1;
    cfg_tdata <= word;
    @(posedge clk);
    while (!cfg_tready) @(posedge clk);
    board.set_size(word);
    @(negedge clk);
    cfg_tvalid <= 1'b0;
  endtask

  task automatic random_request(bit gaps);
    logic [1:0] kind;
    logic [9:0] lo, hi;
    logic [29:0] v;
    int pick;
    pick = $urandom_range(0, 99);
    kind = pick < 45 ? REQ_ASSIGN : (pick < 75 ? REQ_QUERY : (pick < 97 ? REQ_POINT
                                                                        : REQ_UNUSED));
    lo = 10'($urandom_range(0, span > 1 ? span + 2 : 3) % 1024);
    hi = $urandom_range(0, 3) == 0 ? 10'($urandom_range(0, 1023)) :
         10'((lo + $urandom_range(0, span / 2 + 1)) % 1024);
    v = $urandom_range(0, 7) == 0 ? 30'($urandom()) : 30'($urandom_range(0, 1000));
    send_request(kind, lo, hi, v, gaps);
  endtask

  initial begin
    logic [15:0] sizes[6];
    board = new();
    board.clear_store();
    idle_cycles = 0;
    hold_cycles = 0;
    sink_wild = 1'b0;
    span = LEAVES;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    send_request(REQ_QUERY, 10'd0, 10'd1023, 30'd0, 1'b0);
    send_request(REQ_POINT, 10'd1023, 10'd0, 30'd0, 1'b0);
    send_request(REQ_ASSIGN, 10'd0, 10'd1023, 30'h3FFF_FFFF, 1'b0);
    send_request(REQ_QUERY, 10'd0, 10'd1023, 30'd0, 1'b0);
    send_request(REQ_ASSIGN, 10'd5, 10'd9, 30'd0, 1'b0);
    send_request(REQ_ASSIGN, 10'd9, 10'd5, 30'd7, 1'b0);
    send_request(REQ_QUERY, 10'd3, 10'd20, 30'd0, 1'b0);
    send_request(REQ_QUERY, 10'd20, 10'd3, 30'd0, 1'b0);
    send_request(REQ_POINT, 10'd7, 10'd0, 30'd0, 1'b0);
    send_request(REQ_POINT, 10'd1023, 10'd1023, 30'd0, 1'b0);
    send_request(REQ_UNUSED, 10'd0, 10'd1023, 30'd5, 1'b0);
    send_request(REQ_ASSIGN, 10'd1023, 10'd1023, 30'd1000000009, 1'b0);
    send_request(REQ_QUERY, 10'd1000, 10'd1023, 30'd0, 1'b0);
    write_size(16'd0);
    send_request(REQ_POINT, 10'd0, 10'd0, 30'd0, 1'b0);
    send_request(REQ_POINT, 10'd1, 10'd0, 30'd0, 1'b0);
    send_request(REQ_QUERY, 10'd0, 10'd1023, 30'd0, 1'b0);
    write_size(16'hFFFF);
    send_request(REQ_QUERY, 10'd0, 10'd1023, 30'd0, 1'b0);
    send_request(REQ_ASSIGN, 10'd3, 10'd1023, 30'd12345, 1'b0);
    send_request(REQ_QUERY, 10'd2, 10'd4, 30'd0, 1'b0);

    hold_cycles = 400;
    for (int k = 0; k < 8; k++) random_request(1'b0);
    drain();

    sink_wild = 1'b1;
    sizes = '{16'd1, 16'd2, 16'd37, 16'd1024, 16'd513, 16'd1025};
    foreach (sizes[s]) begin
      write_size(sizes[s]);
      span = sizes[s][10:0] == 0 ? 1 : (sizes[s][10:0] > LEAVES ? LEAVES : sizes[s][10:0]);
      for (int k = 0; k < 160; k++) random_request(k % 40 < 30);
    end

    drain();
    if (board.mismatches == 0)
      $display("tb_range_assign_range_min_tree: done, clean");
    else
      $display("tb_range_assign_range_min_tree: done, errors");
    $finish;
  end

endmodule

// ===== range_assign_range_min_tree.f =====
sv/rmt_pkg.sv
sv/rmt_ram.sv
sv/rmt_ctrl.sv
sv/rmt_dp.sv
sv/range_assign_range_min_tree.sv
sim/tb_range_assign_range_min_tree.sv
